[rtl/ialu_pkg.sv]
// Shared constants, operation codes and sequencer states for the integer ALU.
`default_nettype none

package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OPND_W         = 32;
    localparam int OP_W           = 3;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_REM = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS_A,
        ST_ABS_B,
        ST_STEP,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

[rtl/integer_alu_mul_div.sv]
// Add, subtract and a zero divisor go straight from idle to the finish state; multiply steps
// once per multiplier bit; divide and remainder form magnitudes, then step per quotient bit.
// A single shared adder retires one multiplier or quotient bit per cycle and also forms the
// magnitudes and the sign fix.
// A new beat is taken as soon as the sequencer is idle, even while the last result waits.
// Reset (aresetn, synchronous, active low) clears the sequencer and the output valid.
`default_nettype none

module integer_alu_mul_div #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic        [ialu_pkg::OP_W-1:0]   s_req_type,
    input  wire logic signed [ialu_pkg::OPND_W-1:0] s_operand_a,
    input  wire logic signed [ialu_pkg::OPND_W-1:0] s_operand_b,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [ialu_pkg::OPND_W-1:0]      m_result,
    output logic                                    m_div_by_zero
);

    import ialu_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [DATA_WIDTH-1:0]   acc_reg, acc_next;
    logic [DATA_WIDTH-1:0]   a_reg, a_next;
    logic [DATA_WIDTH-1:0]   b_reg, b_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    neg_q_reg, neg_q_next;
    logic                    neg_r_reg, neg_r_next;
    logic                    dz_reg, dz_next;
    logic                    m_valid_reg, m_valid_next;
    logic [OPND_W-1:0]       m_result_reg, m_result_next;
    logic                    m_dz_reg, m_dz_next;

    // Shared adder
    logic [DATA_WIDTH-1:0]   add_x, add_y;
    logic                    add_cin;
    logic [DATA_WIDTH:0]     add_full;
    logic [DATA_WIDTH-1:0]   add_sum;
    logic                    add_co;

    logic [DATA_WIDTH-1:0]   in_a, in_b, rem_shift;
    logic                    out_free;

    assign add_full = {1'b0, add_x} + {1'b0, add_y} + (DATA_WIDTH + 1)'(add_cin);
    assign add_sum  = add_full[DATA_WIDTH-1:0];
    assign add_co   = add_full[DATA_WIDTH];

    assign in_a      = DATA_WIDTH'($unsigned(s_operand_a));
    assign in_b      = DATA_WIDTH'($unsigned(s_operand_b));
    assign rem_shift = {acc_reg[DATA_WIDTH-2:0], a_reg[DATA_WIDTH-1]};
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_result      = $signed(m_result_reg);
    assign m_div_by_zero = m_dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        acc_reg      <= acc_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        cnt_reg      <= cnt_next;
        neg_q_reg    <= neg_q_next;
        neg_r_reg    <= neg_r_next;
        dz_reg       <= dz_next;
        m_result_reg <= m_result_next;
        m_dz_reg     <= m_dz_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        acc_next      = acc_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        cnt_next      = cnt_reg;
        neg_q_next    = neg_q_reg;
        neg_r_next    = neg_r_reg;
        dz_next       = dz_reg;
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        m_dz_next     = m_dz_reg;
        add_x         = '0;
        add_y         = '0;
        add_cin       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_req_type;
                    a_next     = in_a;
                    b_next     = in_b;
                    acc_next   = '0;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    neg_r_next = in_a[DATA_WIDTH-1];
                    neg_q_next = in_a[DATA_WIDTH-1] ^ in_b[DATA_WIDTH-1];
                    dz_next    = 1'b0;
                    state_next = ST_FIN;
                    if (s_req_type == OP_MUL) begin
                        state_next = ST_STEP;
                    end else if (s_req_type inside {OP_DIV, OP_REM}) begin
                        if (in_b == '0) begin
                            dz_next = 1'b1;
                        end else begin
                            state_next = ST_ABS_A;
                        end
                    end
                end
            end
            ST_ABS_A: begin
                add_x      = neg_r_reg ? ~a_reg : a_reg;
                add_cin    = neg_r_reg;
                a_next     = add_sum;
                state_next = ST_ABS_B;
            end
            ST_ABS_B: begin
                add_x      = (neg_q_reg ^ neg_r_reg) ? ~b_reg : b_reg;
                add_cin    = neg_q_reg ^ neg_r_reg;
                b_next     = add_sum;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (op_reg == OP_MUL) begin
                    add_x    = acc_reg;
                    add_y    = b_reg[0] ? a_reg : '0;
                    acc_next = add_sum;
                    a_next   = {a_reg[DATA_WIDTH-2:0], 1'b0};
                    b_next   = {1'b0, b_reg[DATA_WIDTH-1:1]};
                end else begin
                    // Trial subtract; carry out means the divisor fits
                    add_x    = rem_shift;
                    add_y    = ~b_reg;
                    add_cin  = 1'b1;
                    acc_next = add_co ? add_sum : rem_shift;
                    a_next   = {a_reg[DATA_WIDTH-2:0], add_co};
                end
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_FIN: begin
                case (op_reg)
                    OP_ADD: begin
                        add_x = a_reg;
                        add_y = b_reg;
                    end
                    OP_SUB: begin
                        add_x   = a_reg;
                        add_y   = ~b_reg;
                        add_cin = 1'b1;
                    end
                    OP_MUL: begin
                        add_x = acc_reg;
                    end
                    OP_DIV: begin
                        add_x   = neg_q_reg ? ~a_reg : a_reg;
                        add_cin = neg_q_reg;
                    end
                    OP_REM: begin
                        add_x   = neg_r_reg ? ~acc_reg : acc_reg;
                        add_cin = neg_r_reg;
                    end
                    default: begin
                        add_x = '0;
                    end
                endcase
                // Hold until the output register is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_result_next = dz_reg ? '0 : OPND_W'($signed(add_sum));
                    m_dz_next     = dz_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
